// ----- rtl/tfef_pkg.sv -----
`timescale 1ns / 1ps

package tfef_pkg;

    // Field formats
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int GAMMA_W        = 18;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd43691;

    // One lane per fluid, five conserved fields per fluid
    localparam int N_LANES  = 2;
    localparam int N_FIELDS = 5;

    // Register stages from an accepted beat to the lane output register
    function automatic int lane_latency(input int dw);
        return 3 * dw + 11;
    endfunction

    // Round a bit count up to whole bytes
    function automatic int pad8(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ----- rtl/tfef_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// The quotient clamps to all ones when it does not fit in QW bits.
module tfef_div #(
    parameter int NW  = 64,
    parameter int DVW = 32,
    parameter int QW  = 63
) (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic [NW-1:0]  i_num,
    input  logic [DVW-1:0] i_den,
    output logic [QW-1:0]  o_quo
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DVW) ? HW : DVW;

    logic [CW-1:0]  w_hi;
    logic [CW-1:0]  w_den;
    logic           w_ovf;

    logic [DVW-1:0] r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [QW-1:0]  r_quo [QW+1];
    logic [DVW-1:0] r_den [QW+1];
    logic           r_ovf [QW+1];

    // Check the top part against the divisor before the bit steps
    assign w_hi  = CW'(i_num[NW-1:QW]);
    assign w_den = CW'(i_den);
    assign w_ovf = (w_hi >= w_den);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= w_ovf ? '0 : DVW'(w_hi);
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= w_ovf;
        end
    end

    // One subtract-and-compare per stage
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DVW:0] w_t;
        logic         w_ge;

        assign w_t  = {r_rem[k-1], r_low[k-1][QW-1]};
        assign w_ge = (w_t >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= w_ge ? DVW'(w_t - {1'b0, r_den[k-1]}) : DVW'(w_t);
                r_low[k] <= r_low[k-1] << 1;
                r_quo[k] <= {r_quo[k-1][QW-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[QW] ? '1 : r_quo[QW];

endmodule

// ----- rtl/tfef_lane.sv -----
`timescale 1ns / 1ps

// Flux pipeline for one fluid: five flux terms and the density fault flag.
module tfef_lane #(
    parameter int DW = tfef_pkg::DATA_WIDTH_DEF,
    parameter int FB = tfef_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_adv,
    input  logic [tfef_pkg::GAMMA_W-1:0] i_gamma,
    input  logic [DW-1:0]                i_rho,
    input  logic [DW-1:0]                i_mx,
    input  logic [DW-1:0]                i_my,
    input  logic [DW-1:0]                i_mz,
    input  logic [DW-1:0]                i_energy,
    output logic [DW-1:0]                o_mass,
    output logic [DW-1:0]                o_momx,
    output logic [DW-1:0]                o_momy,
    output logic [DW-1:0]                o_momz,
    output logic [DW-1:0]                o_enflux,
    output logic                         o_fault
);

    localparam int GW  = tfef_pkg::GAMMA_W;
    localparam int QA  = 2 * DW - 1;
    localparam int IW  = 2 * DW + 1;
    localparam int PMW = 2 * DW + GW - FB;
    localparam int PW  = PMW + 1;
    localparam int SW  = ((PW > QA + 1) ? PW : QA + 1) + 1;
    localparam int NE  = DW + SW;
    localparam int LA  = QA + 1;
    localparam int LE  = DW + 1;

    localparam logic [QA-1:0] LIM_POS = QA'({1'b0, {(DW-1){1'b1}}});
    localparam logic [QA-1:0] LIM_NEG = QA'({1'b1, {(DW-1){1'b0}}});
    localparam logic [DW-1:0] MAXV    = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV    = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic          fault;
        logic          nx;
        logic          ny;
        logic          nz;
        logic [DW-1:0] ax;
        logic [DW-1:0] mx;
        logic [DW-1:0] en;
        logic [DW-2:0] r;
    } t_ba;

    typedef struct packed {
        t_ba           a;
        logic [QA-1:0] qxx;
        logic [QA-1:0] qxy;
        logic [QA-1:0] qxz;
    } t_bm;

    typedef struct packed {
        logic          fault;
        logic [DW-1:0] mx;
        logic          se;
        logic [SW-1:0] momx;
        logic          sxy;
        logic [QA-1:0] qxy;
        logic          sxz;
        logic [QA-1:0] qxz;
    } t_be;

    // Saturate a sign and magnitude pair to DW signed bits
    function automatic logic [DW-1:0] f_sat(input logic neg, input logic [QA-1:0] mag);
        logic [DW-1:0] lo;
        lo = mag[DW-1:0];
        if (neg) begin
            return (mag > LIM_NEG) ? MINV : DW'(0) - lo;
        end
        return (mag > LIM_POS) ? MAXV : lo;
    endfunction

    // Stage 1: magnitudes and signs
    t_ba           r_ba1, r_ba2, r_ba3;
    logic [DW-1:0] r_ay1, r_az1;
    logic [DW-1:0] w_ax, w_ay, w_az;

    assign w_ax = i_mx[DW-1] ? DW'(0) - i_mx : i_mx;
    assign w_ay = i_my[DW-1] ? DW'(0) - i_my : i_my;
    assign w_az = i_mz[DW-1] ? DW'(0) - i_mz : i_mz;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ba1.fault <= i_rho[DW-1] | (i_rho == '0);
            r_ba1.nx    <= i_mx[DW-1];
            r_ba1.ny    <= i_my[DW-1];
            r_ba1.nz    <= i_mz[DW-1];
            r_ba1.ax    <= w_ax;
            r_ba1.mx    <= i_mx;
            r_ba1.en    <= i_energy;
            r_ba1.r     <= i_rho[DW-2:0];
            r_ay1       <= w_ay;
            r_az1       <= w_az;
        end
    end

    // Stage 2: momentum products
    logic [2*DW-1:0] r_pxx2, r_pyy2, r_pzz2, r_pxy2, r_pxz2;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pxx2 <= r_ba1.ax * r_ba1.ax;
            r_pyy2 <= r_ay1 * r_ay1;
            r_pzz2 <= r_az1 * r_az1;
            r_pxy2 <= r_ba1.ax * r_ay1;
            r_pxz2 <= r_ba1.ax * r_az1;
            r_ba2  <= r_ba1;
        end
    end

    // Stage 3: sum of squares
    logic [2*DW-1:0] r_sum3, r_pxx3, r_pxy3, r_pxz3;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum3 <= r_pxx2 + r_pyy2 + r_pzz2;
            r_pxx3 <= r_pxx2;
            r_pxy3 <= r_pxy2;
            r_pxz3 <= r_pxz2;
            r_ba3  <= r_ba2;
        end
    end

    // Kinetic energy and momentum flux quotients
    logic [QA-1:0] w_ke, w_qxx, w_qxy, w_qxz;

    tfef_div #(.NW(2*DW), .DVW(DW), .QW(QA)) u_div_ke (
        .i_clk (i_clk), .i_adv (i_adv), .i_num (r_sum3),
        .i_den ({r_ba3.r, 1'b0}), .o_quo (w_ke)
    );
    tfef_div #(.NW(2*DW), .DVW(DW-1), .QW(QA)) u_div_xx (
        .i_clk (i_clk), .i_adv (i_adv), .i_num (r_pxx3),
        .i_den (r_ba3.r), .o_quo (w_qxx)
    );
    tfef_div #(.NW(2*DW), .DVW(DW-1), .QW(QA)) u_div_xy (
        .i_clk (i_clk), .i_adv (i_adv), .i_num (r_pxy3),
        .i_den (r_ba3.r), .o_quo (w_qxy)
    );
    tfef_div #(.NW(2*DW), .DVW(DW-1), .QW(QA)) u_div_xz (
        .i_clk (i_clk), .i_adv (i_adv), .i_num (r_pxz3),
        .i_den (r_ba3.r), .o_quo (w_qxz)
    );

    // Delay the side data alongside the dividers
    t_ba r_bad [LA];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bad[0] <= r_ba3;
            for (int k = 1; k < LA; k++) begin
                r_bad[k] <= r_bad[k-1];
            end
        end
    end

    // Stage 4: energy less kinetic energy
    t_bm             r_bm4, r_bm5, r_bm6, r_bm7, r_bm8, r_bm9;
    logic signed [IW-1:0] w_inner;
    logic [IW-1:0]   w_inner_mag;
    logic            r_pneg4, r_pneg5;
    logic [2*DW-1:0] r_pm4;

    assign w_inner = $signed({{(IW-DW){r_bad[LA-1].en[DW-1]}}, r_bad[LA-1].en})
                   - $signed({2'b00, w_ke});
    assign w_inner_mag = w_inner[IW-1] ? IW'(0) - w_inner : w_inner;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pneg4   <= w_inner[IW-1];
            r_pm4     <= w_inner_mag[2*DW-1:0];
            r_bm4.a   <= r_bad[LA-1];
            r_bm4.qxx <= w_qxx;
            r_bm4.qxy <= w_qxy;
            r_bm4.qxz <= w_qxz;
        end
    end

    // Stage 5: scale by gamma minus one in two partial products
    logic [DW+GW-1:0] r_plo5, r_phi5;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_plo5  <= r_pm4[DW-1:0] * i_gamma;
            r_phi5  <= r_pm4[2*DW-1:DW] * i_gamma;
            r_pneg5 <= r_pneg4;
            r_bm5   <= r_bm4;
        end
    end

    // Stage 6: combine partials, drop fraction bits, apply sign
    logic [2*DW+GW-1:0] w_pfull;
    logic [PMW-1:0]     w_pmag;
    logic [PW-1:0]      r_p6;

    assign w_pfull = {r_phi5, DW'(0)} + (2*DW+GW)'(r_plo5);
    assign w_pmag  = w_pfull[2*DW+GW-1:FB];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p6  <= r_pneg5 ? PW'(0) - {1'b0, w_pmag} : {1'b0, w_pmag};
            r_bm6 <= r_bm5;
        end
    end

    // Stage 7: energy plus pressure and x momentum flux
    logic [SW-1:0] w_p_x, w_s, w_smag;
    logic [SW-1:0] r_smag7, r_momx7, r_momx8, r_momx9;
    logic          r_sneg7, r_sneg8, r_sneg9;

    assign w_p_x  = {{(SW-PW){r_p6[PW-1]}}, r_p6};
    assign w_s    = {{(SW-DW){r_bm6.a.en[DW-1]}}, r_bm6.a.en} + w_p_x;
    assign w_smag = w_s[SW-1] ? SW'(0) - w_s : w_s;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sneg7 <= w_s[SW-1];
            r_smag7 <= w_smag;
            r_momx7 <= {{(SW-QA){1'b0}}, r_bm6.qxx} + w_p_x;
            r_bm7   <= r_bm6;
        end
    end

    // Stage 8: x momentum times energy term, two partials
    logic [2*DW-1:0] r_elo8;
    logic [SW-1:0]   r_ehi8;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_elo8  <= r_bm7.a.ax * r_smag7[DW-1:0];
            r_ehi8  <= SW'(r_bm7.a.ax * r_smag7[SW-1:DW]);
            r_sneg8 <= r_sneg7;
            r_momx8 <= r_momx7;
            r_bm8   <= r_bm7;
        end
    end

    // Stage 9: combine partials
    logic [NE-1:0] r_n9;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_n9    <= {r_ehi8, DW'(0)} + NE'(r_elo8);
            r_sneg9 <= r_sneg8;
            r_momx9 <= r_momx8;
            r_bm9   <= r_bm8;
        end
    end

    // Energy flux quotient, clamped once it leaves DW bits
    logic [DW-1:0] w_qe;

    tfef_div #(.NW(NE), .DVW(DW-1), .QW(DW)) u_div_e (
        .i_clk (i_clk), .i_adv (i_adv), .i_num (r_n9),
        .i_den (r_bm9.a.r), .o_quo (w_qe)
    );

    t_be w_be;
    t_be r_bed [LE];

    always_comb begin
        w_be.fault = r_bm9.a.fault;
        w_be.mx    = r_bm9.a.mx;
        w_be.se    = r_bm9.a.nx ^ r_sneg9;
        w_be.momx  = r_momx9;
        w_be.sxy   = r_bm9.a.nx ^ r_bm9.a.ny;
        w_be.qxy   = r_bm9.qxy;
        w_be.sxz   = r_bm9.a.nx ^ r_bm9.a.nz;
        w_be.qxz   = r_bm9.qxz;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bed[0] <= w_be;
            for (int k = 1; k < LE; k++) begin
                r_bed[k] <= r_bed[k-1];
            end
        end
    end

    // Final stage: saturate, zero the fluid on a density fault
    t_be           w_bl;
    logic          w_momx_fits;
    logic [DW-1:0] w_momx_sat;

    assign w_bl        = r_bed[LE-1];
    assign w_momx_fits = (&w_bl.momx[SW-1:DW-1]) | ~(|w_bl.momx[SW-1:DW-1]);
    assign w_momx_sat  = w_momx_fits ? w_bl.momx[DW-1:0]
                       : (w_bl.momx[SW-1] ? MINV : MAXV);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_fault <= w_bl.fault;
            if (w_bl.fault) begin
                o_mass   <= '0;
                o_momx   <= '0;
                o_momy   <= '0;
                o_momz   <= '0;
                o_enflux <= '0;
            end else begin
                o_mass   <= w_bl.mx;
                o_momx   <= w_momx_sat;
                o_momy   <= f_sat(w_bl.sxy, w_bl.qxy);
                o_momz   <= f_sat(w_bl.sxz, w_bl.qxz);
                o_enflux <= f_sat(w_bl.se, QA'(w_qe));
            end
        end
    end

endmodule

// ----- rtl/two_fluid_euler_flux_core.sv -----
`timescale 1ns / 1ps

// Two-fluid ideal-gas Euler flux, x direction.
// Input stream: one beat per grid point, the ion fields then the electron
// fields (density, momentum x, y, z, energy), each DATA_WIDTH bits signed
// with FRAC_BITS fraction bits. Output stream: one beat per input beat, the
// five flux terms of the ions then of the electrons, saturated; tuser
// flags a nonpositive density per fluid, whose flux terms then read zero.
// Configuration: one write channel loads gamma minus one (unsigned Q2.16);
// write it only while no beats are in flight.
// Throughput: one beat per cycle while the receiver does not stall. The
// pipeline depth from input accept to output valid is set by the
// bit-per-stage divider chains: kinetic energy, then the energy flux quotient.
// Both fluids run in their own lane side by side; an output register and a
// skid register follow the merge.
// Reset clears the pipeline valid bits and the output stage and loads
// gamma minus one with two thirds. When the receiver stalls, the skid
// register takes the next result and s_axis_tready drops while it is full,
// freezing the pipeline until the output drains.
module two_fluid_euler_flux_core #(
    parameter int FRAC_BITS  = tfef_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = tfef_pkg::DATA_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    // Configuration write: gamma_minus_one
    input  logic                                            i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  logic [tfef_pkg::GAMMA_W-1:0]                    i_cfg_data,
    // tdata: ion_density, ion_mom_x, ion_mom_y, ion_mom_z, ion_energy,
    //        elec_density, elec_mom_x, elec_mom_y, elec_mom_z, elec_energy
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    input  logic [tfef_pkg::pad8(10*DATA_WIDTH)-1:0]        s_axis_tdata,
    // tdata: ion_mass_flux, ion_momx_flux, ion_momy_flux, ion_momz_flux,
    //        ion_energy_flux, elec_mass_flux, elec_momx_flux, elec_momy_flux,
    //        elec_momz_flux, elec_energy_flux
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    output logic [tfef_pkg::pad8(10*DATA_WIDTH)-1:0]        m_axis_tdata,
    // tuser: density_fault
    output logic [1:0]                                      m_axis_tuser
);

    localparam int NL  = tfef_pkg::N_LANES;
    localparam int NF  = tfef_pkg::N_FIELDS;
    localparam int LAT = tfef_pkg::lane_latency(DATA_WIDTH);
    localparam int OW  = tfef_pkg::pad8(10 * DATA_WIDTH);

    logic [tfef_pkg::GAMMA_W-1:0] r_gamma;
    logic [LAT-1:0]               r_vld;
    logic                         w_adv;
    logic [NL*NF*DATA_WIDTH-1:0]  w_flux;
    logic [NL-1:0]                w_fault;
    logic [OW-1:0]                r_out_data, r_skid_data, w_tail_data;
    logic [1:0]                   r_out_user, r_skid_user;
    logic                         r_out_v, r_skid_v, w_tail_v;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= tfef_pkg::GAMMA_RESET;
        end else if (i_cfg_valid) begin
            r_gamma <= i_cfg_data;
        end
    end

    // Advance the whole pipeline while the skid register is free
    assign w_adv         = ~r_skid_v;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // One lane per fluid
    for (genvar l = 0; l < NL; l++) begin : g_lane
        localparam int B = l * NF * DATA_WIDTH;
        tfef_lane #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_adv    (w_adv),
            .i_gamma  (r_gamma),
            .i_rho    (s_axis_tdata[B +: DATA_WIDTH]),
            .i_mx     (s_axis_tdata[B + DATA_WIDTH +: DATA_WIDTH]),
            .i_my     (s_axis_tdata[B + 2*DATA_WIDTH +: DATA_WIDTH]),
            .i_mz     (s_axis_tdata[B + 3*DATA_WIDTH +: DATA_WIDTH]),
            .i_energy (s_axis_tdata[B + 4*DATA_WIDTH +: DATA_WIDTH]),
            .o_mass   (w_flux[B +: DATA_WIDTH]),
            .o_momx   (w_flux[B + DATA_WIDTH +: DATA_WIDTH]),
            .o_momy   (w_flux[B + 2*DATA_WIDTH +: DATA_WIDTH]),
            .o_momz   (w_flux[B + 3*DATA_WIDTH +: DATA_WIDTH]),
            .o_enflux (w_flux[B + 4*DATA_WIDTH +: DATA_WIDTH]),
            .o_fault  (w_fault[l])
        );
    end

    // Merge the lanes into one result beat
    assign w_tail_data = OW'(w_flux);
    assign w_tail_v    = r_vld[LAT-1];

    // Output register with skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_tail_v) begin
            if (!r_out_v || m_axis_tready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (w_tail_v) begin
            if (!r_out_v || m_axis_tready) begin
                r_out_data <= w_tail_data;
                r_out_user <= w_fault;
            end else begin
                r_skid_data <= w_tail_data;
                r_skid_user <= w_fault;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/tfef_chk.sv -----
`timescale 1ns / 1ps

module tfef_chk #(
    parameter int DW = tfef_pkg::DATA_WIDTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tfef_pkg::pad8(10*DW)-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);

    // Reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

    // A stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // Input backpressure only follows an output stall
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // Faulted fluids carry zero flux
    a_ion_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[5*DW-1:0] == '0)
        else $error("ion flux not zero on density fault");

    a_elec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[10*DW-1:5*DW] == '0)
        else $error("electron flux not zero on density fault");

endmodule

bind two_fluid_euler_flux_core tfef_chk #(.DW(DATA_WIDTH)) u_tfef_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
